>>> hw/rtl/tpc_pkg.sv
// Package for the threshold pixel compaction block: field widths, register
// indexes, entry format codes and reset values. No dependencies.
`default_nettype none

package tpc_pkg;

   // Payload field widths
   localparam int VALUE_W  = 16;
   localparam int COORD_W  = 13;
   localparam int SLOT_W   = 16;
   localparam int COUNT_W  = 17;
   localparam int DIM_W    = 13;
   localparam int FORMAT_W = 2;

   // Control port widths
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ENTRY_FORMAT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_ENTRIES  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

   // Entry format codes
   localparam logic [FORMAT_W-1:0] FMT_COORD    = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_CENTERED = 2'd1;
   localparam logic [FORMAT_W-1:0] FMT_FLOW     = 2'd2;
   localparam logic [FORMAT_W-1:0] FMT_HOUGH    = 2'd3;

   // Register reset values
   localparam logic [VALUE_W-1:0]  RST_THRESHOLD    = 16'd0;
   localparam logic [FORMAT_W-1:0] RST_ENTRY_FORMAT = FMT_COORD;
   localparam logic [COUNT_W-1:0]  RST_MAX_ENTRIES  = 17'd65536;
   localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;

   // Saturation point of the kept-pixel counter
   localparam logic [COUNT_W-1:0] KEPT_SAT = '1;

   // Default sizing
   localparam int DEF_MAX_WIDTH   = 4096;
   localparam int DEF_MAX_HEIGHT  = 4096;
   localparam int DEF_MAX_ENTRIES = 65536;

endpackage

`default_nettype wire

>>> hw/rtl/tpc_if.sv
// Channel interfaces of the threshold pixel compaction block: pixel input,
// entry result and register write. Depends on tpc_pkg.
`default_nettype none

interface tpc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [tpc_pkg::VALUE_W-1:0]  compare_value;
   logic signed [tpc_pkg::VALUE_W-1:0]  flow_u;
   logic signed [tpc_pkg::VALUE_W-1:0]  flow_v;

   modport source (output valid, compare_value, flow_u, flow_v, input ready);
   modport sink   (input valid, compare_value, flow_u, flow_v, output ready);
endinterface

interface tpc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                entry_valid;
   logic        [tpc_pkg::SLOT_W-1:0]   entry_slot;
   logic signed [tpc_pkg::COORD_W-1:0]  out_x;
   logic signed [tpc_pkg::COORD_W-1:0]  out_y;
   logic signed [tpc_pkg::VALUE_W-1:0]  out_u;
   logic signed [tpc_pkg::VALUE_W-1:0]  out_v;
   logic        [tpc_pkg::VALUE_W-1:0]  out_strength;
   logic                                frame_done;
   logic        [tpc_pkg::COUNT_W-1:0]  total_count;

   modport source (output valid, entry_valid, entry_slot, out_x, out_y, out_u, out_v,
                   out_strength, frame_done, total_count, input ready);
   modport sink   (input valid, entry_valid, entry_slot, out_x, out_y, out_u, out_v,
                   out_strength, frame_done, total_count, output ready);
endinterface

interface tpc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tpc_pkg::CSR_ADDR_W-1:0]       index;
   logic [tpc_pkg::CSR_DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/threshold_pixel_compaction.sv
// Top level of the threshold pixel compaction block: pixel stream in, packed
// entry stream out, register write port. Depends on tpc_pkg and tpc_if.
`default_nettype none

// Takes one pixel per cycle in raster order and keeps its own column and row.
// A pixel whose compare_value is at or above threshold becomes an entry at the
// next list slot while the slot is below capacity; the last pixel of a frame
// carries the kept count, capped at the capacity. A pixel passes through the
// input register and then the result register, and the block sustains one
// pixel per cycle as long as the result side keeps taking beats. The column,
// row and kept-count update feeds back on its own registers. Pixels that
// neither become an entry nor end a frame produce no result beat. Register
// writes are always ready and must be issued only while the block is idle.

module threshold_pixel_compaction #(
   parameter int MAX_WIDTH   = tpc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT  = tpc_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_ENTRIES = tpc_pkg::DEF_MAX_ENTRIES
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tpc_req_if.sink    req_if,
   tpc_rsp_if.source  rsp_if,
   tpc_csr_if.sink    csr_if
);
   import tpc_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int CALC_W = COUNT_W + 1;
   localparam int CAP_W  = 32;

   // Configuration registers
   logic signed [VALUE_W-1:0]  threshold_ff;
   logic [FORMAT_W-1:0]        entry_format_ff;
   logic [COUNT_W-1:0]         max_entries_ff;
   logic [DIM_W-1:0]           image_width_ff;
   logic [DIM_W-1:0]           image_height_ff;

   // Input register
   logic                       in_valid_ff;
   logic signed [VALUE_W-1:0]  in_cv_ff;
   logic signed [VALUE_W-1:0]  in_fu_ff;
   logic signed [VALUE_W-1:0]  in_fv_ff;

   // Frame state
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COUNT_W-1:0] kept_ff, kept_in;

   // Result register
   logic                       out_valid_ff;
   logic                       ent_valid_ff, ent_valid_in;
   logic [SLOT_W-1:0]          slot_ff, slot_in;
   logic signed [COORD_W-1:0]  x_ff, x_in;
   logic signed [COORD_W-1:0]  y_ff, y_in;
   logic signed [VALUE_W-1:0]  u_ff, u_in;
   logic signed [VALUE_W-1:0]  v_ff, v_in;
   logic [VALUE_W-1:0]         str_ff, str_in;
   logic                       done_ff, done_in;
   logic [COUNT_W-1:0]         total_ff, total_in;

   // Derived values
   logic [COUNT_W-1:0]  w_eff, h_eff, w_half, h_half;
   logic [COUNT_W-1:0]  cap;
   logic [COUNT_W-1:0]  col_ext, row_ext;
   logic                keep, last_col, produce, advance;
   logic signed [CALC_W-1:0] cx_full, cy_full;

   // Register writes; unknown indexes are ignored
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= RST_THRESHOLD;
         entry_format_ff <= RST_ENTRY_FORMAT;
         max_entries_ff  <= RST_MAX_ENTRIES;
         image_width_ff  <= RST_IMAGE_WIDTH;
         image_height_ff <= RST_IMAGE_HEIGHT;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_THRESHOLD:    threshold_ff    <= csr_if.data[VALUE_W-1:0];
            REG_ENTRY_FORMAT: entry_format_ff <= csr_if.data[FORMAT_W-1:0];
            REG_MAX_ENTRIES:  max_entries_ff  <= csr_if.data[COUNT_W-1:0];
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_if.data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_if.data[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp dimensions (zero taken as one) and capacity to the sized limits
   always_comb begin
      w_eff = (image_width_ff == '0) ? COUNT_W'(1) : COUNT_W'(image_width_ff);
      if (w_eff > COUNT_W'(MAX_WIDTH)) w_eff = COUNT_W'(MAX_WIDTH);
      h_eff = (image_height_ff == '0) ? COUNT_W'(1) : COUNT_W'(image_height_ff);
      if (h_eff > COUNT_W'(MAX_HEIGHT)) h_eff = COUNT_W'(MAX_HEIGHT);
      if (CAP_W'(max_entries_ff) > CAP_W'(MAX_ENTRIES)) begin
         cap = COUNT_W'(MAX_ENTRIES);
      end else begin
         cap = max_entries_ff;
      end
      w_half = w_eff >> 1;
      h_half = h_eff >> 1;
   end

   // Stage handshake: advance a valid input pixel unless its result beat is blocked by a held one
   assign col_ext  = COUNT_W'(col_ff);
   assign row_ext  = COUNT_W'(row_ff);
   assign keep     = (in_cv_ff >= threshold_ff);
   assign last_col = (col_ext >= w_eff - COUNT_W'(1));
   assign done_in  = last_col && (row_ext >= h_eff - COUNT_W'(1));
   assign ent_valid_in = keep && (kept_ff < cap);
   assign produce  = ent_valid_in || done_in;
   assign advance  = in_valid_ff && (!produce || !out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_cv_ff <= req_if.compare_value;
         in_fu_ff <= req_if.flow_u;
         in_fv_ff <= req_if.flow_v;
      end
   end

   // Build the entry fields
   assign cx_full = $signed({1'b0, col_ext}) - $signed({1'b0, w_half});
   assign cy_full = $signed({1'b0, h_half}) - $signed({1'b0, row_ext});

   always_comb begin
      slot_in = '0;
      x_in    = '0;
      y_in    = '0;
      u_in    = '0;
      v_in    = '0;
      str_in  = '0;
      if (ent_valid_in) begin
         slot_in = kept_ff[SLOT_W-1:0];
         x_in    = col_ext[COORD_W-1:0];
         y_in    = row_ext[COORD_W-1:0];
         case (entry_format_ff)
            FMT_CENTERED: begin
               x_in = cx_full[COORD_W-1:0];
               y_in = cy_full[COORD_W-1:0];
            end
            FMT_FLOW: begin
               u_in = in_fu_ff;
               v_in = in_fv_ff;
            end
            FMT_HOUGH: begin
               str_in = in_cv_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Advance column, row and kept count; report the count at frame end
   always_comb begin
      kept_in  = kept_ff;
      if (keep && (kept_ff != KEPT_SAT)) kept_in = kept_ff + COUNT_W'(1);
      total_in = '0;
      if (done_in) total_in = (kept_in < cap) ? kept_in : cap;
      col_in   = col_ff + COL_W'(1);
      row_in   = row_ff;
      if (done_in) begin
         col_in  = '0;
         row_in  = '0;
         kept_in = '0;
      end else if (last_col) begin
         col_in  = '0;
         row_in  = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         kept_ff <= '0;
      end else if (advance) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         kept_ff <= kept_in;
      end
   end

   // Result register: load on a producing advance, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && produce) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         ent_valid_ff <= ent_valid_in;
         slot_ff      <= slot_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         u_ff         <= u_in;
         v_ff         <= v_in;
         str_ff       <= str_in;
         done_ff      <= done_in;
         total_ff     <= total_in;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.entry_valid  = ent_valid_ff;
   assign rsp_if.entry_slot   = slot_ff;
   assign rsp_if.out_x        = x_ff;
   assign rsp_if.out_y        = y_ff;
   assign rsp_if.out_u        = u_ff;
   assign rsp_if.out_v        = v_ff;
   assign rsp_if.out_strength = str_ff;
   assign rsp_if.frame_done   = done_ff;
   assign rsp_if.total_count  = total_ff;

endmodule

`default_nettype wire

>>> sim/tb_threshold_pixel_compaction.sv
// Testbench for threshold_pixel_compaction: directed and random pixel streams
// checked against a cycle-free entry predictor kept in a small scoreboard class.
// Depends on tpc_pkg, tpc_if and the block's RTL.

module tb_threshold_pixel_compaction;

   import tpc_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_SPARE = 3'd7;
   localparam int CYCLE_LIMIT = 500_000;

   typedef struct packed {
      logic signed [VALUE_W-1:0] compare_value;
      logic signed [VALUE_W-1:0] flow_u;
      logic signed [VALUE_W-1:0] flow_v;
   } pixel_type;

   typedef struct packed {
      logic                      entry_valid;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [VALUE_W-1:0] u;
      logic signed [VALUE_W-1:0] v;
      logic [VALUE_W-1:0]        strength;
      logic                      frame_done;
      logic [COUNT_W-1:0]        total;
   } entry_type;

   // Mirror of the block's registers and raster position; holds the entries
   // still owed by the block, oldest first.
   class entry_tracker;
      logic signed [VALUE_W-1:0] threshold;
      logic [FORMAT_W-1:0]       format;
      logic [COUNT_W-1:0]        max_entries;
      logic [DIM_W-1:0]          width_reg;
      logic [DIM_W-1:0]          height_reg;
      logic [11:0]               column;
      logic [11:0]               row;
      logic [COUNT_W-1:0]        kept;
      entry_type                 due_entries[$];
      int                        mismatches;

      function new();
         threshold   = RST_THRESHOLD;
         format      = RST_ENTRY_FORMAT;
         max_entries = RST_MAX_ENTRIES;
         width_reg   = RST_IMAGE_WIDTH;
         height_reg  = RST_IMAGE_HEIGHT;
         column      = '0;
         row         = '0;
         kept        = '0;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_THRESHOLD:    threshold   = data[VALUE_W-1:0];
            REG_ENTRY_FORMAT: format      = data[FORMAT_W-1:0];
            REG_MAX_ENTRIES:  max_entries = data[COUNT_W-1:0];
            REG_IMAGE_WIDTH:  width_reg   = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: height_reg  = data[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      // Predict the entry for one accepted pixel and advance the raster position.
      function void take_pixel(pixel_type p);
         int        w;
         int        h;
         int        cap;
         entry_type e;
         logic      last_col;
         logic      done;
         w = (width_reg == 0) ? 1 :
             ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg);
         h = (height_reg == 0) ? 1 :
             ((height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg);
         cap = (max_entries > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : max_entries;
         e = '0;
         if ($signed(p.compare_value) >= $signed(threshold)) begin
            if (kept < cap) begin
               e.entry_valid = 1'b1;
               e.slot        = kept[SLOT_W-1:0];
               e.x           = COORD_W'(column);
               e.y           = COORD_W'(row);
               case (format)
                  FMT_CENTERED: begin
                     e.x = COORD_W'(int'(column) - w / 2);
                     e.y = COORD_W'(h / 2 - int'(row));
                  end
                  FMT_FLOW: begin
                     e.u = p.flow_u;
                     e.v = p.flow_v;
                  end
                  FMT_HOUGH: e.strength = p.compare_value;
                  default: ;
               endcase
            end
            if (kept != KEPT_SAT) kept = kept + 1'b1;
         end
         last_col = (column >= w - 1);
         done     = last_col && (row >= h - 1);
         if (done) begin
            e.frame_done = 1'b1;
            e.total      = (kept < cap) ? kept : COUNT_W'(cap);
            column       = '0;
            row          = '0;
            kept         = '0;
         end else if (last_col) begin
            column = '0;
            row    = row + 1'b1;
         end else begin
            column = column + 1'b1;
         end
         if (e.entry_valid || e.frame_done) due_entries.push_back(e);
      endfunction

      function void show(string tag, entry_type e);
         $display("  %s: valid=%0b slot=%0d x=%0d y=%0d u=%0d v=%0d str=%0d done=%0b total=%0d",
                  tag, e.entry_valid, e.slot, e.x, e.y, e.u, e.v, e.strength,
                  e.frame_done, e.total);
      endfunction

      // Compare one result beat with the oldest owed entry.
      function void match_entry(entry_type got);
         entry_type want;
         if (due_entries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result beat with no entry owed");
               show("actual", got);
            end
            return;
         end
         want = due_entries.pop_front();
         if (got.entry_valid !== want.entry_valid || got.slot !== want.slot ||
             got.x !== want.x || got.y !== want.y || got.u !== want.u || got.v !== want.v ||
             got.strength !== want.strength || got.frame_done !== want.frame_done ||
             got.total !== want.total) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("entry mismatch");
               show("expected", want);
               show("actual", got);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   tpc_req_if req ();
   tpc_rsp_if rsp ();
   tpc_csr_if csr ();

   threshold_pixel_compaction dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   entry_tracker tracker;
   int idle_pct;
   int stall_pct;
   int hold_left;
   int cycle_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Drive result ready: hold off while a long stall is pending, else stall at random
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         tracker.match_entry({rsp.entry_valid, rsp.entry_slot, rsp.out_x, rsp.out_y,
                              rsp.out_u, rsp.out_v, rsp.out_strength, rsp.frame_done,
                              rsp.total_count});
   end

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= index;
      csr.data  <= data;
      do @(posedge clock); while (!csr.ready);
      tracker.write_reg(index, data);
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   // Write all five registers; junk in unused upper data bits must be ignored
   task automatic setup(input logic signed [VALUE_W-1:0] thr, input logic [FORMAT_W-1:0] fmt,
                        input logic [COUNT_W-1:0] max_n, input logic [DIM_W-1:0] w,
                        input logic [DIM_W-1:0] h);
      write_reg(REG_THRESHOLD, {1'($urandom), thr});
      write_reg(REG_ENTRY_FORMAT, {15'($urandom), fmt});
      write_reg(REG_MAX_ENTRIES, max_n);
      write_reg(REG_IMAGE_WIDTH, {4'($urandom), w});
      write_reg(REG_IMAGE_HEIGHT, {4'($urandom), h});
   endtask

   // Offer one pixel beat after a random gap and wait until it is taken
   task automatic send_pixel(input logic signed [VALUE_W-1:0] cv,
                             input logic signed [VALUE_W-1:0] fu,
                             input logic signed [VALUE_W-1:0] fv);
      pixel_type p;
      int        gap;
      p   = {cv, fu, fv};
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      repeat (gap) begin
         @(negedge clock);
         req.valid <= 1'b0;
      end
      @(negedge clock);
      req.valid         <= 1'b1;
      req.compare_value <= cv;
      req.flow_u        <= fu;
      req.flow_v        <= fv;
      do @(posedge clock); while (!req.ready);
      tracker.take_pixel(p);
   endtask

   // Drop valid, wait for every owed entry, then let silent pixels drain
   task automatic settle();
      @(negedge clock);
      req.valid <= 1'b0;
      while (tracker.due_entries.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic random_setting(input int pixels, input int hold);
      logic signed [VALUE_W-1:0] thr;
      logic signed [VALUE_W-1:0] cv;
      logic [FORMAT_W-1:0]       fmt;
      logic [COUNT_W-1:0]        max_n;
      logic [DIM_W-1:0]          w;
      logic [DIM_W-1:0]          h;
      case ($urandom_range(4))
         0: thr = VALUE_W'($urandom);
         1: thr = 16'sh8000;
         2: thr = 16'sh7FFF;
         default: thr = VALUE_W'(int'($urandom_range(512)) - 256);
      endcase
      fmt = FORMAT_W'($urandom_range(3));
      case ($urandom_range(5))
         0: max_n = '0;
         1: max_n = COUNT_W'($urandom_range(1, 8));
         2: max_n = 17'd65536;
         3: max_n = '1;
         4: max_n = COUNT_W'($urandom);
         default: max_n = COUNT_W'($urandom_range(9, 200));
      endcase
      case ($urandom_range(7))
         0: w = '0;
         1: w = DIM_W'($urandom);
         default: w = DIM_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(7))
         0: h = '0;
         1: h = DIM_W'($urandom);
         default: h = DIM_W'($urandom_range(1, 6));
      endcase
      setup(thr, fmt, max_n, w, h);
      if (hold > 0) begin
         @(posedge clock);
         hold_left = hold;
      end
      repeat (pixels) begin
         case ($urandom_range(3))
            1: cv = thr + 16'($urandom_range(4)) - 16'd2;
            2: cv = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: cv = VALUE_W'($urandom);
         endcase
         send_pixel(cv, 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      tracker           = new();
      idle_pct          = 0;
      stall_pct         = 0;
      hold_left         = 0;
      reset             <= 1'b1;
      req.valid         <= 1'b0;
      req.compare_value <= '0;
      req.flow_u        <= '0;
      req.flow_v        <= '0;
      csr.valid         <= 1'b0;
      csr.index         <= '0;
      csr.data          <= '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Plain coordinates; threshold edges, value extremes, a spare index ignored
      setup(16'sd0, FMT_COORD, 17'd65536, 13'd3, 13'd2);
      write_reg(REG_SPARE, CSR_DATA_W'($urandom));
      send_pixel(16'sd0, 16'sh7FFF, 16'sh8000);
      send_pixel(-16'sd1, 16'sh8000, 16'sh7FFF);
      send_pixel(16'sh7FFF, 16'sh5555, 16'shAAAA);
      send_pixel(16'sh8000, 16'shAAAA, 16'sh5555);
      send_pixel(16'sd1, 16'sd0, -16'sd1);
      send_pixel(16'sd0, -16'sd1, 16'sd0);
      settle();

      // Centered, width zero taken as one, capacity fills after two entries
      setup(16'sh8000, FMT_CENTERED, 17'd2, 13'd0, 13'd2);
      send_pixel(16'sh8000, 16'sd0, 16'sd0);
      send_pixel(16'sd5, 16'sd0, 16'sd0);
      send_pixel(16'sh7FFF, 16'sd0, 16'sd0);
      settle();

      // Flow with capacity zero and oversized dimensions
      setup(16'sh7FFF, FMT_FLOW, 17'd0, 13'd8191, 13'd8191);
      send_pixel(16'sh7FFF, 16'sh7FFF, 16'sh8000);
      send_pixel(16'sh7FFE, 16'sh8000, 16'sh7FFF);
      send_pixel(16'sh8000, 16'sd1, 16'sd1);
      settle();

      // Hough with oversized capacity over two frames of one row
      setup(-16'sd5, FMT_HOUGH, 17'h1FFFF, 13'd2, 13'd1);
      send_pixel(-16'sd5, 16'sh1234, 16'sh4321);
      send_pixel(-16'sd6, 16'sd0, 16'sd0);
      send_pixel(16'sh7FFF, 16'sd0, 16'sd0);
      send_pixel(16'sh8000, 16'sd0, 16'sd0);
      settle();

      // Centered at the largest image
      setup(16'sh8000, FMT_CENTERED, 17'd65536, 13'd4096, 13'd4096);
      send_pixel(16'sd0, 16'sd0, 16'sd0);
      send_pixel(16'sd0, 16'sd0, 16'sd0);
      send_pixel(16'sd0, 16'sd0, 16'sd0);
      settle();

      // Flow pass-through extremes with a single slot
      setup(16'sh8000, FMT_FLOW, 17'd1, 13'd5, 13'd1);
      send_pixel(16'sd0, 16'sh7FFF, 16'sh8000);
      send_pixel(16'sd0, 16'sh8000, 16'sh7FFF);
      send_pixel(16'sd0, 16'sh5555, 16'shAAAA);
      send_pixel(16'sd0, 16'shAAAA, 16'sh5555);
      settle();

      // Random settings under each idling mix; first one holds the result side off
      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 80; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 80; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         for (int s = 0; s < 6; s++) begin
            random_setting(75, (mix == 0 && s == 0) ? 300 : 0);
            settle();
         end
      end

      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.due_entries.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
